// File: rtl/pcenc_pkg.sv
// Shared types, constants and helper functions of the Playfair encryption block.
`default_nettype none

package pcenc_pkg;

    // Letter codes, A=0 .. Z=25
    localparam logic [4:0] CODE_I    = 5'd8;
    localparam logic [4:0] CODE_J    = 5'd9;
    localparam logic [4:0] CODE_Q    = 5'd16;
    localparam logic [4:0] CODE_X    = 5'd23;
    localparam logic [4:0] LAST_CODE = 5'd25;

    // Square geometry
    localparam int         SQ_DEPTH   = 25;
    localparam int         POS_DEPTH  = 26;
    localparam int         SQ_AW      = $clog2(SQ_DEPTH);
    localparam int         POS_AW     = $clog2(POS_DEPTH);
    localparam logic [4:0] CELLS      = 5'd25;
    localparam logic [4:0] LAST_CELL  = 5'd24;
    localparam logic [2:0] LAST_INDEX = 3'd4;

    // Stream widths
    localparam int DATA_W = 8;
    localparam int CMD_W  = 3;

    typedef enum logic [2:0] {
        CMD_KEY_START  = 3'd0,
        CMD_KEY_LETTER = 3'd1,
        CMD_KEY_FINISH = 3'd2,
        CMD_PLAIN      = 3'd3,
        CMD_MSG_END    = 3'd4
    } t_cmd;

    typedef struct packed {
        logic       pair_end;
        logic [4:0] cipher_letter;
    } t_out_word;

    typedef struct packed {
        logic      load;
        t_out_word word;
    } t_out_req;

    // Slot among the 25 square letters, J folded out
    function automatic logic [4:0] slot_of(input logic [4:0] code);
        return (code > CODE_J) ? code - 5'd1 : code;
    endfunction

    function automatic logic [4:0] code_of_slot(input logic [4:0] slot);
        return (slot <= CODE_I) ? slot : slot + 5'd1;
    endfunction

    function automatic logic [4:0] filler_for(input logic [4:0] code);
        return (code == CODE_X) ? CODE_Q : CODE_X;
    endfunction

    // Step a row or column index by one, wrapping at the edge
    function automatic logic [2:0] inc_wrap(input logic [2:0] x);
        return (x == LAST_INDEX) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic logic [2:0] row_of(input logic [4:0] p);
        logic [2:0] r;
        priority if (p >= 5'd20) r = 3'd4;
        else if (p >= 5'd15)     r = 3'd3;
        else if (p >= 5'd10)     r = 3'd2;
        else if (p >= 5'd5)      r = 3'd1;
        else                     r = 3'd0;
        return r;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    function automatic logic [2:0] col_of(input logic [4:0] p);
        logic [4:0] base;
        logic [4:0] diff;
        base = cell_of(row_of(p), 3'd0);
        diff = p - base;
        return diff[2:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/pcenc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pcenc_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/pcenc_outbuf.sv
// Output register of the cipher word stream.
`default_nettype none

module pcenc_outbuf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pcenc_pkg::t_out_req i_req,
    output logic                     o_free,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic [pcenc_pkg::DATA_W-1:0] o_m_tdata,
    output logic                     o_m_tlast
);

    logic                 r_valid;
    pcenc_pkg::t_out_word r_word;

    assign o_free     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(pcenc_pkg::DATA_W - 5){1'b0}}, r_word.cipher_letter};
    assign o_m_tlast  = r_word.pair_end;

    // Load a new word or drop the one taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold payload while not loading
    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_word <= i_req.word;
        end
    end

endmodule

`default_nettype wire

// File: rtl/pcenc_ctrl.sv
// Sequencer: key square build, pairing and lookups in the square memories.
`default_nettype none

module pcenc_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [pcenc_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [4:0]             i_letter,
    input  wire logic                   i_out_free,
    output pcenc_pkg::t_out_req         o_out_req
);

    typedef enum logic [2:0] {
        S_IDLE, S_FILL, S_POSA, S_POSB, S_SQ1, S_SQ2, S_OUT1, S_OUT2
    } t_state;

    t_state      r_state, n_state;
    logic [24:0] r_seen, n_seen;
    logic [4:0]  r_fill, n_fill;
    logic        r_key_ready, n_key_ready;
    logic [4:0]  r_pend, n_pend;
    logic        r_pend_valid, n_pend_valid;
    logic [4:0]  r_scan, n_scan;
    logic [4:0]  r_b, n_b;
    logic [4:0]  r_pa, n_pa;
    logic [4:0]  r_c2, n_c2;
    logic [4:0]  r_q1, n_q1;
    logic [4:0]  r_q2, n_q2;

    logic [4:0] w_code;
    logic [4:0] w_slot;
    logic       w_in_range;
    logic       w_we;
    logic [4:0] w_wcode;
    logic [4:0] w_pair_a;
    logic [4:0] w_pair_b;
    logic       w_start_pair;

    logic [pcenc_pkg::POS_AW-1:0] w_pos_raddr;
    logic [4:0]                   w_pos_rdata;
    logic [pcenc_pkg::SQ_AW-1:0]  w_sq_raddr;
    logic [4:0]                   w_sq_rdata;

    logic [2:0] w_ra, w_ca, w_rb, w_cb;
    logic [4:0] w_c1, w_c2;

    assign o_ready    = (r_state == S_IDLE);
    assign w_code     = (i_letter == pcenc_pkg::CODE_J) ? pcenc_pkg::CODE_I : i_letter;
    assign w_slot     = pcenc_pkg::slot_of(w_code);
    assign w_in_range = (w_code <= pcenc_pkg::LAST_CODE);

    // Cipher cells from the two positions: row shift, column shift or rectangle
    always_comb begin
        w_ra = pcenc_pkg::row_of(r_pa);
        w_ca = pcenc_pkg::col_of(r_pa);
        w_rb = pcenc_pkg::row_of(w_pos_rdata);
        w_cb = pcenc_pkg::col_of(w_pos_rdata);
        if (w_ra == w_rb) begin
            w_c1 = pcenc_pkg::cell_of(w_ra, pcenc_pkg::inc_wrap(w_ca));
            w_c2 = pcenc_pkg::cell_of(w_rb, pcenc_pkg::inc_wrap(w_cb));
        end else if (w_ca == w_cb) begin
            w_c1 = pcenc_pkg::cell_of(pcenc_pkg::inc_wrap(w_ra), w_ca);
            w_c2 = pcenc_pkg::cell_of(pcenc_pkg::inc_wrap(w_rb), w_cb);
        end else begin
            w_c1 = pcenc_pkg::cell_of(w_ra, w_cb);
            w_c2 = pcenc_pkg::cell_of(w_rb, w_ca);
        end
    end

    // Read addresses: position lookups first, then square lookups
    assign w_pos_raddr = (r_state == S_POSA) ? r_b : w_pair_a;
    assign w_sq_raddr  = (r_state == S_SQ1) ? r_c2 : w_c1;

    // Key square: cell -> letter
    pcenc_ram #(.WIDTH(5), .DEPTH(pcenc_pkg::SQ_DEPTH)) u_square (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_fill),
        .i_wdata (w_wcode),
        .i_raddr (w_sq_raddr),
        .o_rdata (w_sq_rdata)
    );

    // Letter position: letter -> cell
    pcenc_ram #(.WIDTH(5), .DEPTH(pcenc_pkg::POS_DEPTH)) u_position (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_wcode),
        .i_wdata (r_fill),
        .i_raddr (w_pos_raddr),
        .o_rdata (w_pos_rdata)
    );

    // Next state: writes only in the key phase, reads only in the text phase
    always_comb begin
        n_state      = r_state;
        n_seen       = r_seen;
        n_fill       = r_fill;
        n_key_ready  = r_key_ready;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_scan       = r_scan;
        n_b          = r_b;
        n_pa         = r_pa;
        n_c2         = r_c2;
        n_q1         = r_q1;
        n_q2         = r_q2;
        w_we         = 1'b0;
        w_wcode      = w_code;
        w_pair_a     = r_pend;
        w_pair_b     = w_code;
        w_start_pair = 1'b0;
        o_out_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_cmd)
                        pcenc_pkg::CMD_KEY_START: begin
                            n_seen       = '0;
                            n_fill       = '0;
                            n_key_ready  = 1'b0;
                            n_pend       = '0;
                            n_pend_valid = 1'b0;
                        end
                        pcenc_pkg::CMD_KEY_LETTER: begin
                            if (!r_key_ready && w_in_range && !r_seen[w_slot]) begin
                                n_seen[w_slot] = 1'b1;
                                if (r_fill < pcenc_pkg::CELLS) begin
                                    w_we   = 1'b1;
                                    n_fill = r_fill + 5'd1;
                                end
                            end
                        end
                        pcenc_pkg::CMD_KEY_FINISH: begin
                            if (!r_key_ready) begin
                                n_scan  = '0;
                                n_state = S_FILL;
                            end
                        end
                        pcenc_pkg::CMD_PLAIN: begin
                            if (r_key_ready && w_in_range) begin
                                if (!r_pend_valid) begin
                                    n_pend       = w_code;
                                    n_pend_valid = 1'b1;
                                end else if (r_pend == w_code) begin
                                    // doubled letter: split by filler, letter keeps waiting
                                    w_pair_a     = w_code;
                                    w_pair_b     = pcenc_pkg::filler_for(w_code);
                                    w_start_pair = 1'b1;
                                end else begin
                                    n_pend_valid = 1'b0;
                                    w_start_pair = 1'b1;
                                end
                            end
                        end
                        pcenc_pkg::CMD_MSG_END: begin
                            if (r_key_ready && r_pend_valid) begin
                                w_pair_b     = pcenc_pkg::filler_for(r_pend);
                                n_pend_valid = 1'b0;
                                w_start_pair = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (w_start_pair) begin
                        n_b     = w_pair_b;
                        n_state = S_POSA;
                    end
                end
            end
            S_FILL: begin
                // place the unseen letters in alphabet order
                w_wcode = pcenc_pkg::code_of_slot(r_scan);
                if (!r_seen[r_scan]) begin
                    n_seen[r_scan] = 1'b1;
                    if (r_fill < pcenc_pkg::CELLS) begin
                        w_we   = 1'b1;
                        n_fill = r_fill + 5'd1;
                    end
                end
                if (r_scan == pcenc_pkg::LAST_CELL) begin
                    n_key_ready  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end else begin
                    n_scan = r_scan + 5'd1;
                end
            end
            S_POSA: begin
                n_pa    = w_pos_rdata;
                n_state = S_POSB;
            end
            S_POSB: begin
                n_c2    = w_c2;
                n_state = S_SQ1;
            end
            S_SQ1: begin
                n_q1    = w_sq_rdata;
                n_state = S_SQ2;
            end
            S_SQ2: begin
                n_q2    = w_sq_rdata;
                n_state = S_OUT1;
            end
            S_OUT1: begin
                if (i_out_free) begin
                    o_out_req.load                = 1'b1;
                    o_out_req.word.pair_end       = 1'b0;
                    o_out_req.word.cipher_letter  = r_q1;
                    n_state                       = S_OUT2;
                end
            end
            S_OUT2: begin
                if (i_out_free) begin
                    o_out_req.load                = 1'b1;
                    o_out_req.word.pair_end       = 1'b1;
                    o_out_req.word.cipher_letter  = r_q2;
                    n_state                       = S_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seen       <= '0;
            r_fill       <= '0;
            r_key_ready  <= 1'b0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_scan       <= '0;
        end else begin
            r_state      <= n_state;
            r_seen       <= n_seen;
            r_fill       <= n_fill;
            r_key_ready  <= n_key_ready;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_scan       <= n_scan;
        end
    end

    // Pair datapath
    always_ff @(posedge i_clk) begin
        r_b  <= n_b;
        r_pa <= n_pa;
        r_c2 <= n_c2;
        r_q1 <= n_q1;
        r_q2 <= n_q2;
    end

    // A finished key has every letter placed once
    a_key_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_ready |-> ((&r_seen) && (r_fill == pcenc_pkg::CELLS)))
        else $error("key ready with an incomplete square");

    // A waiting letter exists only in the text phase
    a_pend_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> r_key_ready)
        else $error("waiting letter outside the text phase");

    // The fill sweep runs only while the key is open
    a_fill_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (!r_key_ready && !r_pend_valid))
        else $error("fill sweep after key finish");

    // The last fill step closes the key
    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_scan == pcenc_pkg::LAST_CELL) |=>
            (r_key_ready && r_state == S_IDLE))
        else $error("fill sweep did not close the key");

endmodule

`default_nettype wire

// File: rtl/playfair_cipher_encrypt.sv
// Top level of the Playfair encryption block.
`default_nettype none

// Playfair encryption over letter codes A=0..Z=25. Input words carry the
// command in tuser and the letter in tdata; output words carry one cipher
// letter each, with tlast set on the second letter of a pair. The key
// square and the letter-to-cell map live in two small RAMs. key_finish
// fills the unplaced letters one square cell per cycle through the
// single write port. A plain letter or message_end that closes a pair
// runs two position reads and two square reads, one after the other on
// each RAM's single read port, then two loads into the output register,
// which wait while the output side stalls. The next input word is taken
// as soon as the second cipher letter sits in the output register.
module playfair_cipher_encrypt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,  // [4:0] letter
    input  wire logic [2:0]  i_s_tuser,  // [2:0] command
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,  // [4:0] cipher_letter
    output logic             o_m_tlast
);

    pcenc_pkg::t_out_req w_out_req;
    logic                w_out_free;

    pcenc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_letter   (i_s_tdata[4:0]),
        .i_out_free (w_out_free),
        .o_out_req  (w_out_req)
    );

    pcenc_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_out_req),
        .o_free     (w_out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
